// ===== hdl/hdu_pkg.sv =====
// Shared types and constants for the half-duplex 8N1 UART.
// No dependencies; every module imports this package.
`timescale 1ns / 1ps

package hdu_pkg;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_PERIOD  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_PERIOD = 1'b1;

   localparam logic [15:0] BIT_PERIOD_RESET  = 16'd103;
   localparam logic [14:0] HALF_PERIOD_RESET = 15'd52;

   localparam int FRAME_W = 10;

   localparam logic [3:0] RX_BITS = 4'hA;
   localparam logic [3:0] TX_BITS = 4'h9;

   typedef struct packed {
      logic       rx_level;
      logic       send_valid;
      logic [7:0] send_byte;
   } req_type;

   typedef struct packed {
      logic       tx_level;
      logic       send_accepted;
      logic       recv_valid;
      logic [7:0] recv_byte;
      logic [1:0] busy_res;
   } rsp_type;

endpackage

// ===== hdl/hdu_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on nothing beyond plain logic types.
`timescale 1ns / 1ps

interface hdu_req_if;
   logic       valid;
   logic       ready;
   logic       rx_level;
   logic       send_valid;
   logic [7:0] send_byte;

   modport source (output valid, rx_level, send_valid, send_byte, input ready);
   modport sink   (input valid, rx_level, send_valid, send_byte, output ready);
endinterface

interface hdu_rsp_if;
   logic       valid;
   logic       ready;
   logic       tx_level;
   logic       send_accepted;
   logic       recv_valid;
   logic [7:0] recv_byte;
   logic [1:0] busy_res;

   modport source (output valid, tx_level, send_accepted, recv_valid, recv_byte, busy_res,
                   input ready);
   modport sink   (input valid, tx_level, send_accepted, recv_valid, recv_byte, busy_res,
                   output ready);
endinterface

// ===== hdl/hdu_core.sv =====
// Bit timer, transmit shifter and receive sampler; one tick per accepted transfer.
// Holds the period registers. Depends on hdu_pkg.
`timescale 1ns / 1ps

module hdu_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [hdu_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [hdu_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             step,
   input  hdu_pkg::req_type                 req,
   output hdu_pkg::rsp_type                 rsp
);
   import hdu_pkg::*;

   typedef enum logic [1:0] {
      ACT_IDLE = 2'd0,
      ACT_TX   = 2'd1,
      ACT_RX   = 2'd2
   } activity_type;

   activity_type       activity_ff, activity_in;
   logic [15:0]        tick_count_ff, tick_count_in;
   logic [3:0]         bits_left_ff, bits_left_in;
   logic [FRAME_W-1:0] shift_word_ff, shift_word_in;
   logic               line_out_ff, line_out_in;
   logic               last_rx_ff, last_rx_in;
   logic [15:0]        bit_period_ff;
   logic [14:0]        half_period_ff;

   logic [FRAME_W-1:0] shift_rx;
   logic [3:0]         bits_dec;
   logic               accepted;
   logic               got;
   logic [7:0]         rbyte;

   always_comb begin
      activity_in   = activity_ff;
      tick_count_in = tick_count_ff;
      bits_left_in  = bits_left_ff;
      shift_word_in = shift_word_ff;
      line_out_in   = line_out_ff;
      last_rx_in    = req.rx_level;
      accepted      = 1'b0;
      got           = 1'b0;
      rbyte         = 8'd0;
      shift_rx      = {req.rx_level, shift_word_ff[FRAME_W-1:1]};
      bits_dec      = bits_left_ff - 4'd1;

      unique case (activity_ff)
         ACT_TX: begin
            if (tick_count_ff >= bit_period_ff) begin
               if (bits_left_ff == 4'd0) begin
                  activity_in = ACT_IDLE;
                  line_out_in = 1'b1;
               end else begin
                  line_out_in   = shift_word_ff[0];
                  shift_word_in = {1'b0, shift_word_ff[FRAME_W-1:1]};
                  bits_left_in  = bits_dec;
                  tick_count_in = 16'd1;
               end
            end else begin
               tick_count_in = tick_count_ff + 16'd1;
            end
         end
         ACT_RX: begin
            if (tick_count_ff <= 16'd1) begin
               shift_word_in = shift_rx;
               tick_count_in = bit_period_ff;
               bits_left_in  = bits_dec;
               if (bits_dec == 4'd0) begin
                  activity_in = ACT_IDLE;
                  if (shift_rx[FRAME_W-1] && !shift_rx[0]) begin
                     got   = 1'b1;
                     rbyte = shift_rx[8:1];
                  end
               end
            end else begin
               tick_count_in = tick_count_ff - 16'd1;
            end
         end
         default: begin
            activity_in = ACT_IDLE;
            if (last_rx_ff && !req.rx_level) begin
               activity_in   = ACT_RX;
               tick_count_in = {1'b0, half_period_ff};
               bits_left_in  = RX_BITS;
               shift_word_in = '0;
            end else if (req.send_valid) begin
               // start bit goes out now; the rest waits in the shifter
               activity_in   = ACT_TX;
               accepted      = 1'b1;
               line_out_in   = 1'b0;
               shift_word_in = {1'b0, 1'b1, req.send_byte};
               bits_left_in  = TX_BITS;
               tick_count_in = 16'd1;
            end
         end
      endcase

      rsp.tx_level      = line_out_in;
      rsp.send_accepted = accepted;
      rsp.recv_valid    = got;
      rsp.recv_byte     = rbyte;
      rsp.busy_res      = activity_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         activity_ff    <= ACT_IDLE;
         tick_count_ff  <= '0;
         bits_left_ff   <= '0;
         shift_word_ff  <= '0;
         line_out_ff    <= 1'b1;
         last_rx_ff     <= 1'b1;
         bit_period_ff  <= BIT_PERIOD_RESET;
         half_period_ff <= HALF_PERIOD_RESET;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_BIT_PERIOD:  bit_period_ff  <= csr_wdata;
               CSR_HALF_PERIOD: half_period_ff <= csr_wdata[14:0];
               default: ;
            endcase
         end
         if (step) begin
            activity_ff   <= activity_in;
            tick_count_ff <= tick_count_in;
            bits_left_ff  <= bits_left_in;
            shift_word_ff <= shift_word_in;
            line_out_ff   <= line_out_in;
            last_rx_ff    <= last_rx_in;
         end
      end
   end

   a_accept_from_idle: assert property (@(posedge clock) disable iff (reset)
      step && rsp.send_accepted |-> activity_ff == ACT_IDLE && req.send_valid)
      else $error("send taken while not idle");

   a_recv_on_last_sample: assert property (@(posedge clock) disable iff (reset)
      step && rsp.recv_valid |-> activity_ff == ACT_RX && bits_left_ff == 4'd1)
      else $error("byte delivered off the tenth sample");

   a_rx_count_range: assert property (@(posedge clock) disable iff (reset)
      activity_ff == ACT_RX |-> bits_left_ff != 4'd0 && bits_left_ff <= RX_BITS)
      else $error("receive bit count out of range");

endmodule

// ===== hdl/hdu_skid.sv =====
// Two-slot response queue between the tick logic and the response channel.
// Depends on hdu_pkg.
`timescale 1ns / 1ps

module hdu_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hdu_pkg::rsp_type push_data,
   output logic             in_ready,
   output logic             out_valid,
   input  logic             out_ready,
   output hdu_pkg::rsp_type out_data
);
   import hdu_pkg::*;

   rsp_type    head_ff, head_in;
   rsp_type    tail_ff, tail_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = head_ff;
   assign pop       = out_valid && out_ready;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      case (count_ff)
         2'd0: begin
            if (push) begin
               head_in  = push_data;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_in = push_data;
            end else if (push) begin
               tail_in  = push_data;
               count_in = 2'd2;
            end else if (pop) begin
               count_in = 2'd0;
            end
         end
         default: begin
            if (pop) begin
               head_in  = tail_ff;
               count_in = 2'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

// ===== hdl/half_duplex_uart_8n1.sv =====
// Half-duplex 8N1 UART, top level: request/response channels and register port.
// Depends on hdu_pkg, hdu_if, hdu_core and hdu_skid.
//
// Each request transfer is one tick of the bit timer and carries the receive
// line level and an optional byte to send. Each request produces exactly one
// response transfer: the transmit line level, whether the send was taken, a
// received byte with its valid flag, and the activity code.
// Throughput: one request per cycle while the queue has room; the tick logic is one
// register stage and a single pass of compare-and-update logic.
// The response for a request is registered into a two-slot queue and is offered
// once the responses queued ahead of it have been taken.
// Stall: while the response side holds off, the queue absorbs one more
// response; with both slots full req_if.ready drops and the timer stops
// advancing until a response is taken.
// Reset: line idle at mark, no activity, bit period 103 and half period 52
// ticks, queue empty. Write the periods through csr_* only while idle.
`timescale 1ns / 1ps

module half_duplex_uart_8n1 (
   input  logic                             clock,
   input  logic                             reset,
   hdu_req_if.sink                          req_if,
   hdu_rsp_if.source                        rsp_if,
   input  logic                             csr_we,
   input  logic [hdu_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [hdu_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import hdu_pkg::*;

   req_type req;
   rsp_type core_rsp;
   rsp_type out_rsp;
   logic    step;
   logic    in_ready;

   assign req.rx_level   = req_if.rx_level;
   assign req.send_valid = req_if.send_valid;
   assign req.send_byte  = req_if.send_byte;

   assign req_if.ready = in_ready;
   assign step         = req_if.valid && in_ready;

   hdu_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (step),
      .req       (req),
      .rsp       (core_rsp)
   );

   hdu_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .push_data (core_rsp),
      .in_ready  (in_ready),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (out_rsp)
   );

   assign rsp_if.tx_level      = out_rsp.tx_level;
   assign rsp_if.send_accepted = out_rsp.send_accepted;
   assign rsp_if.recv_valid    = out_rsp.recv_valid;
   assign rsp_if.recv_byte     = out_rsp.recv_byte;
   assign rsp_if.busy_res      = out_rsp.busy_res;

endmodule

// ===== tb/half_duplex_uart_8n1_tb.sv =====
`timescale 1ns / 1ps
// Testbench for half_duplex_uart_8n1: a short table of directed ticks, then random receive
// frames, send requests and line noise, every response checked against its table row or a cycle-exact model.
// Depends on hdu_pkg, the hdu_req_if/hdu_rsp_if interfaces and the half_duplex_uart_8n1 RTL.

module half_duplex_uart_8n1_tb;
   import hdu_pkg::*;

   localparam int STUCK_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 20;
   localparam int MAX_PRINTED   = 40;
   localparam int DIR_ROWS      = 30;

   typedef enum logic [1:0] {
      ACT_IDLE = 2'd0,
      ACT_SEND = 2'd1,
      ACT_RECV = 2'd2
   } act_type;

   typedef enum logic {ROW_TICK, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      logic                    rx;
      logic                    sv;
      logic [7:0]              sb;
      logic                    typed;
      rsp_type                 want;
      logic [CSR_INDEX_W-1:0]  reg_sel;
      logic [CSR_DATA_W-1:0]   reg_val;
   } stim_row_type;

   localparam rsp_type NO_RSP = '0;

   logic                    clock;
   logic                    reset;
   logic                    csr_we;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   hdu_req_if req_bus ();
   hdu_rsp_if rsp_bus ();

   half_duplex_uart_8n1 dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // transceiver model state and its copy of the period registers
   logic [15:0] cfg_bit_ticks  = BIT_PERIOD_RESET;
   logic [14:0] cfg_half_ticks = HALF_PERIOD_RESET;
   act_type     act            = ACT_IDLE;
   logic [15:0] tmr            = '0;
   logic [3:0]  bits_todo      = '0;
   logic [9:0]  shreg          = '0;
   logic        tx_line        = 1'b1;
   logic        rx_last        = 1'b1;

   rsp_type     tick_results[$];
   rsp_type     want_rsp;
   int          items_sent     = 0;
   int          rsp_seen       = 0;
   int          err_count      = 0;
   int          stuck_cycles   = 0;
   bit          calm_tail      = 1'b0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic rsp_type uart_tick(input req_type item);
      rsp_type    o;
      logic [9:0] frame;
      o = NO_RSP;
      case (act)
         ACT_SEND: begin
            if (tmr >= cfg_bit_ticks) begin
               if (bits_todo == 4'd0) begin
                  act     = ACT_IDLE;
                  tx_line = 1'b1;
               end else begin
                  tx_line   = shreg[0];
                  shreg     = shreg >> 1;
                  bits_todo = bits_todo - 4'd1;
                  tmr       = 16'd1;
               end
            end else begin
               tmr = tmr + 16'd1;
            end
         end
         ACT_RECV: begin
            if (tmr <= 16'd1) begin
               shreg     = {item.rx_level, shreg[9:1]};
               tmr       = cfg_bit_ticks;
               bits_todo = bits_todo - 4'd1;
               if (bits_todo == 4'd0) begin
                  act = ACT_IDLE;
                  if (shreg[9] && !shreg[0]) begin
                     o.recv_valid = 1'b1;
                     o.recv_byte  = shreg[8:1];
                  end
               end
            end else begin
               tmr = tmr - 16'd1;
            end
         end
         default: begin
            act = ACT_IDLE;
            if (rx_last && !item.rx_level) begin
               act       = ACT_RECV;
               tmr       = {1'b0, cfg_half_ticks};
               bits_todo = RX_BITS;
               shreg     = '0;
            end else if (item.send_valid) begin
               frame           = {1'b1, item.send_byte, 1'b0};
               act             = ACT_SEND;
               o.send_accepted = 1'b1;
               tx_line         = frame[0];
               shreg           = frame >> 1;
               bits_todo       = TX_BITS;
               tmr             = 16'd1;
            end
         end
      endcase
      rx_last    = item.rx_level;
      o.tx_level = tx_line;
      o.busy_res = act;
      return o;
   endfunction

   task automatic flag_error(input string msg);
      if (err_count < MAX_PRINTED)
         $display("[%0t] mismatch: %s", $time, msg);
      err_count++;
   endtask

   task automatic tick_uart(input logic rx, input logic sv, input logic [7:0] sb,
                            input logic typed = 1'b0, input rsp_type want = NO_RSP);
      req_type item;
      rsp_type pred;
      int      gap;
      item = {rx, sv, sb};
      if (!calm_tail && $urandom_range(0, 15) == 0) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         gap = $urandom_range(1, 19);
         repeat (gap) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.rx_level   = rx;
      req_bus.send_valid = sv;
      req_bus.send_byte  = sb;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pred = uart_tick(item);
      tick_results.push_back(typed ? want : pred);
      items_sent++;
   endtask

   task automatic write_period(input logic [CSR_INDEX_W-1:0] sel,
                               input logic [CSR_DATA_W-1:0] val);
      // finish any frame and return the line to mark before touching the timer
      while (act != ACT_IDLE || !rx_last) tick_uart(1'b1, 1'b0, 8'h00);
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (tick_results.size() != 0) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = sel;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      if (sel == CSR_BIT_PERIOD)
         cfg_bit_ticks = val;
      else
         cfg_half_ticks = val[14:0];
   endtask

   task automatic send_rx_frame(input logic [9:0] frame);
      int first_gap;
      int bit_gap;
      int j;
      first_gap = (cfg_half_ticks == 15'd0) ? 1 : cfg_half_ticks;
      bit_gap   = (cfg_bit_ticks <= 16'd1) ? 1 : cfg_bit_ticks;
      tick_uart(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      repeat (first_gap)
         tick_uart(frame[0], 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      for (j = 1; j < FRAME_W; j++)
         repeat (bit_gap)
            tick_uart(frame[j], 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
   endtask

   task automatic send_tx_byte(input logic [7:0] data);
      tick_uart(1'b1, 1'b1, data);
      while (act == ACT_SEND)
         tick_uart(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)));
   endtask

   task automatic run_traffic(input int budget);
      int         stop_at;
      int         pick;
      logic [7:0] data;
      logic       start_bit;
      logic       stop_bit;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         pick      = $urandom_range(0, 99);
         data      = 8'($urandom_range(0, 255));
         start_bit = 1'($urandom_range(0, 1));
         stop_bit  = 1'($urandom_range(0, 1));
         if (act != ACT_IDLE || !rx_last)
            tick_uart(1'b1, 1'b0, data);
         else if (pick < 45)
            send_rx_frame({1'b1, data, 1'b0});
         else if (pick < 60)
            send_rx_frame({stop_bit, data, start_bit});
         else if (pick < 85)
            send_tx_byte(data);
         else
            repeat ($urandom_range(1, 8))
               tick_uart(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm_tail && $urandom_range(0, 15) == 0) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(0, 18)) @(negedge clock);
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_seen++;
         if (tick_results.size() == 0) begin
            flag_error($sformatf("response %0d with nothing expected", rsp_seen));
         end else begin
            want_rsp = tick_results.pop_front();
            if (rsp_bus.tx_level !== want_rsp.tx_level)
               flag_error($sformatf("rsp %0d tx_level %b, want %b", rsp_seen,
                                    rsp_bus.tx_level, want_rsp.tx_level));
            if (rsp_bus.send_accepted !== want_rsp.send_accepted)
               flag_error($sformatf("rsp %0d send_accepted %b, want %b", rsp_seen,
                                    rsp_bus.send_accepted, want_rsp.send_accepted));
            if (rsp_bus.recv_valid !== want_rsp.recv_valid)
               flag_error($sformatf("rsp %0d recv_valid %b, want %b", rsp_seen,
                                    rsp_bus.recv_valid, want_rsp.recv_valid));
            if (rsp_bus.recv_byte !== want_rsp.recv_byte)
               flag_error($sformatf("rsp %0d recv_byte %h, want %h", rsp_seen,
                                    rsp_bus.recv_byte, want_rsp.recv_byte));
            if (rsp_bus.busy_res !== want_rsp.busy_res)
               flag_error($sformatf("rsp %0d busy_res %0d, want %0d", rsp_seen,
                                    rsp_bus.busy_res, want_rsp.busy_res));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      stim_row_type dir_rows [0:DIR_ROWS-1];
      int           i;
      int           bp;
      logic [7:0]   data;

      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_BIT_PERIOD;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.rx_level   = 1'b1;
      req_bus.send_valid = 1'b0;
      req_bus.send_byte  = 8'h00;

      // reset periods: idle
      dir_rows[0] = '{ROW_TICK, 1'b1, 1'b0, 8'h00, 1'b1,
                      {1'b1, 1'b0, 1'b0, 8'h00, ACT_IDLE}, CSR_BIT_PERIOD, 16'd0};
      // bit period 3: take a send, refuse a second, ignore an edge while sending
      dir_rows[1] = '{ROW_CSR, 1'b1, 1'b0, 8'h00, 1'b0, NO_RSP, CSR_BIT_PERIOD, 16'd3};
      dir_rows[2] = '{ROW_TICK, 1'b1, 1'b1, 8'hFF, 1'b1,
                      {1'b0, 1'b1, 1'b0, 8'h00, ACT_SEND}, CSR_BIT_PERIOD, 16'd0};
      dir_rows[3] = '{ROW_TICK, 1'b1, 1'b1, 8'h00, 1'b1,
                      {1'b0, 1'b0, 1'b0, 8'h00, ACT_SEND}, CSR_BIT_PERIOD, 16'd0};
      dir_rows[4] = '{ROW_TICK, 1'b0, 1'b0, 8'h00, 1'b1,
                      {1'b0, 1'b0, 1'b0, 8'h00, ACT_SEND}, CSR_BIT_PERIOD, 16'd0};
      // zero periods: one tick per bit
      dir_rows[5] = '{ROW_CSR, 1'b1, 1'b0, 8'h00, 1'b0, NO_RSP, CSR_BIT_PERIOD, 16'd0};
      dir_rows[6] = '{ROW_CSR, 1'b1, 1'b0, 8'h00, 1'b0, NO_RSP, CSR_HALF_PERIOD, 16'd0};
      // edge and request together: the edge wins
      dir_rows[7] = '{ROW_TICK, 1'b0, 1'b1, 8'hA5, 1'b1,
                      {1'b1, 1'b0, 1'b0, 8'h00, ACT_RECV}, CSR_BIT_PERIOD, 16'd0};
      dir_rows[8] = '{ROW_TICK, 1'b0, 1'b0, 8'h00, 1'b0, NO_RSP, CSR_BIT_PERIOD, 16'd0};
      for (i = 9; i < 17; i++)
         dir_rows[i] = '{ROW_TICK, 1'b1, 1'b1, 8'h3C, 1'b0, NO_RSP, CSR_BIT_PERIOD, 16'd0};
      // stop sample delivers 0xFF and the request on that tick is refused
      dir_rows[17] = '{ROW_TICK, 1'b1, 1'b1, 8'h3C, 1'b1,
                       {1'b1, 1'b0, 1'b1, 8'hFF, ACT_IDLE}, CSR_BIT_PERIOD, 16'd0};
      dir_rows[18] = '{ROW_TICK, 1'b1, 1'b1, 8'h00, 1'b1,
                       {1'b0, 1'b1, 1'b0, 8'h00, ACT_SEND}, CSR_BIT_PERIOD, 16'd0};
      for (i = 19; i < 29; i++)
         dir_rows[i] = '{ROW_TICK, 1'b1, 1'b1, 8'h55, 1'b0, NO_RSP, CSR_BIT_PERIOD, 16'd0};
      dir_rows[29] = '{ROW_TICK, 1'b1, 1'b1, 8'h55, 1'b1,
                       {1'b0, 1'b1, 1'b0, 8'h00, ACT_SEND}, CSR_BIT_PERIOD, 16'd0};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < DIR_ROWS; i++) begin
         if (dir_rows[i].kind == ROW_CSR)
            write_period(dir_rows[i].reg_sel, dir_rows[i].reg_val);
         else
            tick_uart(dir_rows[i].rx, dir_rows[i].sv, dir_rows[i].sb,
                      dir_rows[i].typed, dir_rows[i].want);
      end

      write_period(CSR_BIT_PERIOD, 16'd2);
      write_period(CSR_HALF_PERIOD, 16'd1);
      run_traffic(90);

      write_period(CSR_BIT_PERIOD, 16'd1);
      write_period(CSR_HALF_PERIOD, 16'd0);
      run_traffic(70);

      repeat (3) begin
         bp = $urandom_range(2, 4);
         write_period(CSR_BIT_PERIOD, 16'(bp));
         write_period(CSR_HALF_PERIOD, 16'($urandom_range(1, bp + 2)));
         run_traffic(70);
      end

      // long start offset, one frame
      data = 8'($urandom_range(0, 255));
      write_period(CSR_BIT_PERIOD, 16'd2);
      write_period(CSR_HALF_PERIOD, 16'd40);
      send_rx_frame({1'b1, data, 1'b0});

      calm_tail = 1'b1;
      bp = $urandom_range(2, 3);
      write_period(CSR_BIT_PERIOD, 16'(bp));
      write_period(CSR_HALF_PERIOD, 16'd1);
      run_traffic(70);

      // long bit period, one whole transmit frame
      data = 8'($urandom_range(0, 255));
      write_period(CSR_BIT_PERIOD, 16'd12);
      send_tx_byte(data);

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (tick_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
